[sv/assert_macros.svh]
// assertion helpers shared by the rtl files
// each check is sampled on the rising edge of clk; TDU_ASSERT is off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that is checked once out of reset
`define TDU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that is also checked while reset is high
`define TDU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TDU_ASSERT(label, prop, msg)
`define TDU_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[sv/tdu_pkg.sv]
// ---------------------------------------------------------------------------
// tdu_pkg
// Types and constants of the timebase and decrementer unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdu_pkg;

  localparam int KIND_W   = 4;
  localparam int INDEX_W  = 3;
  localparam int WORD_W   = 32;
  localparam int TB_W     = 64;

  // index compares are done at this width so that bank sizes up to 32 never alias
  localparam int IDX_CMP_W = 5;

  localparam int DEC_FIELD_W  = 6;
  localparam int HDEC_FIELD_W = 3;

  localparam logic [KIND_W-1:0] KIND_TICK     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SET_EN   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_WR_TB_LO = 4'd2;
  localparam logic [KIND_W-1:0] KIND_WR_TB_HI = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RD_TB    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_WR_DEC   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RD_DEC   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_WR_HDEC  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RD_HDEC  = 4'd8;

  localparam logic [WORD_W-1:0] BAD_INDEX_READ = 32'h7FFF_FFFF;

  // control for one counter bank for one transfer
  typedef struct packed {
    logic                step;   // an item is processed this cycle
    logic                tick;   // count down by one
    logic                wr;     // load one counter
    logic [INDEX_W-1:0]  idx;
    logic [WORD_W-1:0]   value;
    logic                run;    // run state after this item
  } bank_ctrl_t;

endpackage

`default_nettype wire

[sv/tdu_counter_bank.sv]
// ---------------------------------------------------------------------------
// tdu_counter_bank
// A bank of 32-bit down counters with arm and expired flags, one per entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tdu_counter_bank #(
  parameter int N = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tdu_pkg::bank_ctrl_t         ctrl,
  output logic [tdu_pkg::WORD_W-1:0]       rd_count,
  output logic [N-1:0]                     flag_next
);

  logic [tdu_pkg::WORD_W-1:0] count      [N];
  logic [tdu_pkg::WORD_W-1:0] count_next [N];
  logic [N-1:0]               armed;
  logic [N-1:0]               armed_next;
  logic [N-1:0]               flag;
  logic [N-1:0]               hit;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit[i] = (tdu_pkg::IDX_CMP_W'(ctrl.idx) == tdu_pkg::IDX_CMP_W'(i));
    end
  end

  // write loads and arms, tick counts down, then the fire check sees the new state
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic armed_pre;
      logic flag_pre;
      logic fire;
      armed_pre = armed[i];
      flag_pre  = flag[i];
      count_next[i] = count[i];
      if (ctrl.wr && hit[i]) begin
        count_next[i] = ctrl.value;
        armed_pre     = 1'b1;
        flag_pre      = 1'b0;
      end else if (ctrl.tick) begin
        count_next[i] = count[i] - tdu_pkg::WORD_W'(1);
      end
      fire          = armed_pre && ctrl.run && count_next[i][tdu_pkg::WORD_W-1];
      armed_next[i] = armed_pre & ~fire;
      flag_next[i]  = flag_pre | fire;
    end
  end

  always_comb begin
    rd_count = tdu_pkg::BAD_INDEX_READ;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        rd_count = count[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
      flag  <= '0;
      for (int i = 0; i < N; i++) begin
        count[i] <= '0;
      end
    end else if (ctrl.step) begin
      armed <= armed_next;
      flag  <= flag_next;
      for (int i = 0; i < N; i++) begin
        count[i] <= count_next[i];
      end
    end
  end

  // a counter is either waiting to fire or has fired, never both
  `TDU_ASSERT_ALWAYS(a_armed_flag_disjoint, (rst || (armed & flag) == '0), "armed and expired both set")
  `TDU_ASSERT(a_hold_when_idle, (!ctrl.step |=> $stable(armed) && $stable(flag)), "bank changed without an item")
  `TDU_ASSERT(a_flag_needs_arm, (ctrl.step && !ctrl.wr |=> (flag & ~$past(flag) & ~$past(armed)) == '0), "flag rose on a counter that was not armed")

endmodule

`default_nettype wire

[sv/timebase_decrementer_unit.sv]
// ---------------------------------------------------------------------------
// timebase_decrementer_unit
// 64-bit timebase with per-thread decrementers and per-core hypervisor
// decrementers, one command in and one status word out per transfer.
// ---------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_ready | kind, index, value, enable
//   out     | out_valid,out_ready| read_data, dec_expired, hdec_expired
//
// one item per cycle sustained while out_ready is high; out_valid rises once the
// item leaves the input register, which feeds one pass of decode, counter update
// and fire check into the result register, which frees as it drains, so a
// stalled out side holds one item in each register before in_ready drops
// rst clears all counters, flags, the run state and both valid bits
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module timebase_decrementer_unit #(
  parameter int NUM_THREADS = 6,
  parameter int NUM_CORES   = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [tdu_pkg::KIND_W-1:0]        kind,
  input  wire logic [tdu_pkg::INDEX_W-1:0]       index,
  input  wire logic [tdu_pkg::WORD_W-1:0]        value,
  input  wire logic                              enable,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tdu_pkg::TB_W-1:0]               read_data,
  output logic [tdu_pkg::DEC_FIELD_W-1:0]        dec_expired,
  output logic [tdu_pkg::HDEC_FIELD_W-1:0]       hdec_expired
);

  localparam int WW = tdu_pkg::WORD_W;

  // input register
  logic                          s1_valid;
  logic [tdu_pkg::KIND_W-1:0]    s1_kind;
  logic [tdu_pkg::INDEX_W-1:0]   s1_index;
  logic [WW-1:0]                 s1_value;
  logic                          s1_enable;
  logic                          adv;

  logic [tdu_pkg::TB_W-1:0]      timebase;
  logic [tdu_pkg::TB_W-1:0]      timebase_next;
  logic                          tb_enabled;
  logic                          tb_enabled_next;
  logic [tdu_pkg::TB_W-1:0]      read_data_next;

  tdu_pkg::bank_ctrl_t           dec_ctrl;
  tdu_pkg::bank_ctrl_t           hdec_ctrl;
  logic [WW-1:0]                 dec_rd;
  logic [WW-1:0]                 hdec_rd;
  logic [NUM_THREADS-1:0]        dec_flag_next;
  logic [NUM_CORES-1:0]          hdec_flag_next;
  logic [tdu_pkg::DEC_FIELD_W-1:0]  dec_field;
  logic [tdu_pkg::HDEC_FIELD_W-1:0] hdec_field;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind   <= kind;
      s1_index  <= index;
      s1_value  <= value;
      s1_enable <= enable;
    end
  end

  always_comb begin
    timebase_next   = timebase;
    tb_enabled_next = tb_enabled;
    read_data_next  = '0;
    unique case (s1_kind)
      tdu_pkg::KIND_TICK: begin
        if (tb_enabled) begin
          timebase_next = timebase + tdu_pkg::TB_W'(1);
        end
      end
      tdu_pkg::KIND_SET_EN:   tb_enabled_next = s1_enable;
      tdu_pkg::KIND_WR_TB_LO: timebase_next = {timebase[tdu_pkg::TB_W-1:WW], s1_value};
      tdu_pkg::KIND_WR_TB_HI: timebase_next = {s1_value, timebase[WW-1:0]};
      tdu_pkg::KIND_RD_TB:    read_data_next = timebase;
      tdu_pkg::KIND_RD_DEC:   read_data_next = {{WW{1'b0}}, dec_rd};
      tdu_pkg::KIND_RD_HDEC:  read_data_next = {{WW{1'b0}}, hdec_rd};
      default: ;
    endcase
  end

  always_comb begin
    dec_ctrl.step  = adv;
    dec_ctrl.tick  = (s1_kind == tdu_pkg::KIND_TICK) && tb_enabled;
    dec_ctrl.wr    = (s1_kind == tdu_pkg::KIND_WR_DEC);
    dec_ctrl.idx   = s1_index;
    dec_ctrl.value = s1_value;
    dec_ctrl.run   = tb_enabled_next;

    hdec_ctrl      = dec_ctrl;
    hdec_ctrl.wr   = (s1_kind == tdu_pkg::KIND_WR_HDEC);
  end

  tdu_counter_bank #(
    .N (NUM_THREADS)
  ) u_dec_bank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (dec_ctrl),
    .rd_count  (dec_rd),
    .flag_next (dec_flag_next)
  );

  tdu_counter_bank #(
    .N (NUM_CORES)
  ) u_hdec_bank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (hdec_ctrl),
    .rd_count  (hdec_rd),
    .flag_next (hdec_flag_next)
  );

  // only the low flags fit the output fields
  always_comb begin
    dec_field = '0;
    for (int b = 0; b < tdu_pkg::DEC_FIELD_W; b++) begin
      if (b < NUM_THREADS) begin
        dec_field[b] = dec_flag_next[b];
      end
    end
    hdec_field = '0;
    for (int b = 0; b < tdu_pkg::HDEC_FIELD_W; b++) begin
      if (b < NUM_CORES) begin
        hdec_field[b] = hdec_flag_next[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timebase   <= '0;
      tb_enabled <= 1'b0;
    end else if (adv) begin
      timebase   <= timebase_next;
      tb_enabled <= tb_enabled_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data    <= read_data_next;
      dec_expired  <= dec_field;
      hdec_expired <= hdec_field;
    end
  end

  `TDU_ASSERT(a_tb_tick, (adv && s1_kind == tdu_pkg::KIND_TICK && tb_enabled |=> timebase == $past(timebase) + tdu_pkg::TB_W'(1)), "timebase missed a tick")
  `TDU_ASSERT(a_state_hold, (!adv |=> $stable(timebase) && $stable(tb_enabled)), "timebase moved without an item")
  `TDU_ASSERT(a_stage_hold, (s1_valid && !adv |=> s1_valid && $stable(s1_kind)), "input stage lost an item")
  `TDU_ASSERT(a_frozen_tick, (adv && s1_kind == tdu_pkg::KIND_TICK && !tb_enabled |=> $stable(timebase)), "timebase counted while frozen")

endmodule

`default_nettype wire

[sim/tb_timebase_decrementer_unit.sv]
// ---------------------------------------------------------------------------
// tb_timebase_decrementer_unit
// Self-checking bench for the timebase and decrementer unit: a directed
// table followed by weighted random commands, every status transfer
// checked against its table row or an in-bench model of the counters and expired flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timebase_decrementer_unit;

  import tdu_pkg::*;

  localparam int N_THREADS    = 6;
  localparam int N_CORES      = 3;
  localparam int RESET_CYCLES = 12;
  localparam int DIR_N        = 28;
  localparam int RAND_N       = 1950;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 80;
  localparam int PAUSE_AT     = 1000;
  localparam int BURST_FROM   = 1200;
  localparam int BURST_TO     = 1500;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(KIND_RD_HDEC + 1);
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

  typedef struct packed {
    logic [TB_W-1:0]         read_data;
    logic [DEC_FIELD_W-1:0]  dec_expired;
    logic [HDEC_FIELD_W-1:0] hdec_expired;
  } tdu_status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
    logic               enable;
    logic               has_status;  // status typed into the table
    tdu_status_t        status;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [KIND_W-1:0]       kind = '0;
  logic [INDEX_W-1:0]      index = '0;
  logic [WORD_W-1:0]       value = '0;
  logic                    enable = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TB_W-1:0]         read_data;
  logic [DEC_FIELD_W-1:0]  dec_expired;
  logic [HDEC_FIELD_W-1:0] hdec_expired;

  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic burst_phase = 1'b0;
  int   stall_left = 0;
  int   fail_count = 0;

  tdu_status_t pending_status[$];

  // model state
  logic [TB_W-1:0]      tb_now;
  logic                 tb_run;
  logic [WORD_W-1:0]    dec_cnt [N_THREADS];
  logic [N_THREADS-1:0] dec_arm;
  logic [N_THREADS-1:0] dec_exp;
  logic [WORD_W-1:0]    hdec_cnt [N_CORES];
  logic [N_CORES-1:0]   hdec_arm;
  logic [N_CORES-1:0]   hdec_exp;

  timebase_decrementer_unit #(
    .NUM_THREADS(N_THREADS),
    .NUM_CORES  (N_CORES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .index       (index),
    .value       (value),
    .enable      (enable),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .dec_expired (dec_expired),
    .hdec_expired(hdec_expired)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // apply one command to the model and return the status it produces
  task automatic predict_status(input stim_row_t it, output tdu_status_t st);
    int t;
    st = '0;
    case (it.kind)
      KIND_TICK: begin
        if (tb_run) begin
          tb_now = tb_now + 1'b1;
          for (t = 0; t < N_THREADS; t++) dec_cnt[t] = dec_cnt[t] - 1'b1;
          for (t = 0; t < N_CORES; t++) hdec_cnt[t] = hdec_cnt[t] - 1'b1;
        end
      end
      KIND_SET_EN:   tb_run = it.enable;
      KIND_WR_TB_LO: tb_now[31:0] = it.value;
      KIND_WR_TB_HI: tb_now[63:32] = it.value;
      KIND_RD_TB:    st.read_data = tb_now;
      KIND_WR_DEC: begin
        if (it.index < N_THREADS) begin
          dec_cnt[it.index] = it.value;
          dec_arm[it.index] = 1'b1;
          dec_exp[it.index] = 1'b0;
        end
      end
      KIND_RD_DEC: begin
        st.read_data = (it.index < N_THREADS) ? {32'h0, dec_cnt[it.index]}
                                              : {32'h0, BAD_INDEX_READ};
      end
      KIND_WR_HDEC: begin
        if (it.index < N_CORES) begin
          hdec_cnt[it.index] = it.value;
          hdec_arm[it.index] = 1'b1;
          hdec_exp[it.index] = 1'b0;
        end
      end
      KIND_RD_HDEC: begin
        st.read_data = (it.index < N_CORES) ? {32'h0, hdec_cnt[it.index]}
                                            : {32'h0, BAD_INDEX_READ};
      end
      default: ;
    endcase
    // one-shot fire once the count goes negative while running
    for (t = 0; t < N_THREADS; t++) begin
      if (dec_arm[t] && tb_run && dec_cnt[t][31]) begin
        dec_exp[t] = 1'b1;
        dec_arm[t] = 1'b0;
      end
    end
    for (t = 0; t < N_CORES; t++) begin
      if (hdec_arm[t] && tb_run && hdec_cnt[t][31]) begin
        hdec_exp[t] = 1'b1;
        hdec_arm[t] = 1'b0;
      end
    end
    st.dec_expired  = dec_exp;
    st.hdec_expired = hdec_exp;
  endtask

  function automatic stim_row_t dir_stim(int n);
    case (n)
      // fresh out of reset
      0:  return '{KIND_RD_TB, 3'd0, 32'h0, 1'b0, 1'b1, '{64'h0, 6'h0, 3'h0}};
      1:  return '{KIND_RD_DEC, 3'd0, 32'h0, 1'b0, 1'b1, '{64'h0, 6'h0, 3'h0}};
      2:  return '{KIND_RD_DEC, 3'd7, 32'h0, 1'b0, 1'b1,
                   '{64'h7FFF_FFFF, 6'h0, 3'h0}};
      3:  return '{KIND_RD_HDEC, 3'd3, 32'h0, 1'b0, 1'b1,
                   '{64'h7FFF_FFFF, 6'h0, 3'h0}};
      4:  return '{KIND_TICK, 3'd0, 32'h0, 1'b0, 1'b1, '{64'h0, 6'h0, 3'h0}};
      5:  return '{KIND_WR_DEC, 3'd6, 32'hFFFF_FFFF, 1'b0, 1'b1,
                   '{64'h0, 6'h0, 3'h0}};
      6:  return '{KIND_WR_TB_LO, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                   '{64'h0, 6'h0, 3'h0}};
      7:  return '{KIND_WR_TB_HI, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                   '{64'h0, 6'h0, 3'h0}};
      8:  return '{KIND_RD_TB, 3'd0, 32'h0, 1'b0, 1'b1,
                   '{64'hFFFF_FFFF_FFFF_FFFF, 6'h0, 3'h0}};
      // armed while frozen: must not fire yet
      9:  return '{KIND_WR_DEC, 3'd0, 32'h8000_0000, 1'b0, 1'b1,
                   '{64'h0, 6'h0, 3'h0}};
      10: return '{KIND_WR_HDEC, 3'd2, 32'h1, 1'b0, 1'b1, '{64'h0, 6'h0, 3'h0}};
      11: return '{KIND_WR_DEC, 3'd5, 32'h0, 1'b0, 1'b1, '{64'h0, 6'h0, 3'h0}};
      12: return '{KIND_WR_HDEC, 3'd7, 32'h8000_0000, 1'b1, 1'b1,
                   '{64'h0, 6'h0, 3'h0}};
      13: return '{KIND_UNUSED_HI, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1,
                   '{64'h0, 6'h0, 3'h0}};
      // from here on the model supplies the status
      14: return '{KIND_SET_EN, 3'd0, 32'h0, 1'b1, 1'b0, '0};
      15: return '{KIND_SET_EN, 3'd0, 32'h0, 1'b1, 1'b0, '0};
      16: return '{KIND_TICK, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      17: return '{KIND_RD_TB, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      18: return '{KIND_TICK, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      19: return '{KIND_RD_DEC, 3'd5, 32'h0, 1'b0, 1'b0, '0};
      20: return '{KIND_RD_HDEC, 3'd2, 32'h0, 1'b0, 1'b0, '0};
      21: return '{KIND_WR_DEC, 3'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, '0};
      22: return '{KIND_WR_DEC, 3'd0, 32'h5, 1'b0, 1'b0, '0};
      23: return '{KIND_SET_EN, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      24: return '{KIND_TICK, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      25: return '{KIND_RD_DEC, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      26: return '{KIND_UNUSED_LO, 3'd0, 32'h0, 1'b0, 1'b0, '0};
      default: return '{KIND_SET_EN, 3'd0, 32'h0, 1'b1, 1'b0, '0};
    endcase
  endfunction

  // mostly short counts so ticks reach the fire point, some negative, some wide
  function automatic logic [WORD_W-1:0] dec_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return WORD_W'($urandom_range(0, 40));
    if (pick < 75) return 32'h8000_0000 | $urandom();
    return $urandom();
  endfunction

  function automatic stim_row_t rand_item();
    stim_row_t it;
    int pick;
    it = '0;
    it.index  = INDEX_W'($urandom_range(0, 7));
    it.value  = $urandom();
    it.enable = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 34) begin
      it.kind = KIND_TICK;
    end else if (pick < 40) begin
      it.kind   = KIND_SET_EN;
      it.enable = ($urandom_range(0, 9) < 8);
    end else if (pick < 45) begin
      it.kind = KIND_WR_TB_LO;
      if ($urandom_range(0, 2) == 0) it.value = 32'hFFFF_FFF0 | WORD_W'($urandom_range(0, 15));
    end else if (pick < 49) begin
      it.kind = KIND_WR_TB_HI;
    end else if (pick < 56) begin
      it.kind = KIND_RD_TB;
    end else if (pick < 70) begin
      it.kind  = KIND_WR_DEC;
      it.value = dec_value();
      if ($urandom_range(0, 9) != 0) it.index = INDEX_W'($urandom_range(0, N_THREADS - 1));
    end else if (pick < 78) begin
      it.kind = KIND_RD_DEC;
    end else if (pick < 86) begin
      it.kind  = KIND_WR_HDEC;
      it.value = dec_value();
      if ($urandom_range(0, 9) != 0) it.index = INDEX_W'($urandom_range(0, N_CORES - 1));
    end else if (pick < 94) begin
      it.kind = KIND_RD_HDEC;
    end else begin
      it.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    return it;
  endfunction

  // command side
  initial begin
    stim_row_t   it;
    tdu_status_t pred;
    int          n;
    bit          in_burst;
    tb_now   = '0;
    tb_run   = 1'b0;
    dec_arm  = '0;
    dec_exp  = '0;
    hdec_arm = '0;
    hdec_exp = '0;
    for (n = 0; n < N_THREADS; n++) dec_cnt[n] = '0;
    for (n = 0; n < N_CORES; n++) hdec_cnt[n] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < DIR_N + RAND_N; n++) begin
      it = (n < DIR_N) ? dir_stim(n) : rand_item();
      in_burst = (n >= BURST_FROM) && (n < BURST_TO);
      if (n == HOLD_AT) hold_req <= 1'b1;
      if (n == BURST_FROM) burst_phase <= 1'b1;
      if (n == BURST_TO) burst_phase <= 1'b0;
      if (n == PAUSE_AT) begin
        // let the unit drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0) @(posedge clk);
      end
      if (!in_burst) begin
        while ($urandom_range(0, 99) < 24) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      kind     <= it.kind;
      index    <= it.index;
      value    <= it.value;
      enable   <= it.enable;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      predict_status(it, pred);
      pending_status.push_back(it.has_status ? it.status : pred);
    end
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // status side back-pressure, with one long hold-off to fill the unit
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready  <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (burst_phase) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 24);
    end
  end

  // compare every status transfer with the oldest expected status
  always @(posedge clk) begin
    tdu_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("unexpected status transfer: read_data=%h dec=%b hdec=%b",
                   read_data, dec_expired, hdec_expired);
        end
        fail_count <= fail_count + 1;
      end else begin
        want = pending_status.pop_front();
        if (read_data !== want.read_data || dec_expired !== want.dec_expired ||
            hdec_expired !== want.hdec_expired) begin
          if (fail_count < MAX_REPORTS) begin
            $display("status mismatch: read_data exp %h got %h, dec exp %b got %b, hdec exp %b got %b",
                     want.read_data, read_data, want.dec_expired, dec_expired,
                     want.hdec_expired, hdec_expired);
          end
          fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule
